>>> design/cdh_pkg.sv
// Package with shared constants and types for the coverage depth histogram.
`default_nettype none
package cdh_pkg;
  localparam int unsigned MaxRefLenDef  = 1048576;
  localparam int unsigned HistBinsDef   = 1024;
  localparam int unsigned DepthWidthDef = 16;
  localparam int unsigned CountWidth    = 40;
  localparam int unsigned ChromWidth    = 16;
  localparam int unsigned LenWidth      = 21;
  localparam int unsigned PosWidth      = 20;
  localparam int unsigned BinWidth      = 10;

  localparam logic [1:0] ModeAlign = 2'd0;
  localparam logic [1:0] ModeFlush = 2'd1;
  localparam logic [1:0] ModeRead  = 2'd2;

  // One classified command from the front part to the back part.
  typedef struct packed {
    logic                  do_sweep;
    logic                  do_incr;
    logic                  do_read;
    logic                  order_err;
    logic [LenWidth-1:0]   new_len;
    logic                  set_len;
    logic [PosWidth-1:0]   start_pos;
    logic [PosWidth-1:0]   end_pos;
    logic [BinWidth-1:0]   bin_index;
  } cmd_t;
endpackage
`default_nettype wire

>>> design/coverage_depth_histogram_top.sv
// Coverage depth histogram: takes sorted alignments, builds a depth histogram.
// Input channel: valid_i/ready_o with one field per port; output channel
// valid_o/ready_i carries order_error_o and bin_count_o, one result beat for
// every input beat, in order.
// Mode 0 beats add one to each depth from start to end (clipped), using one
// depth store read-modify-write per position. A chromosome change or a
// flush first sweeps the previous active length, reading every depth and,
// for a nonzero one, updating its histogram bin. A histogram read raises
// valid_o once the bin count is registered. The back part works on one
// command at a time and takes the next only once the result beat has left;
// a two-beat queue lets the front accept while it is busy.
// After reset the depth store and the histogram are cleared; no beat is
// accepted meanwhile.
// A stalled receiver holds the result register and the back part waits;
// the queue then fills and ready_o drops.
`default_nettype none
module coverage_depth_histogram_top
  import cdh_pkg::*;
#(
  parameter int unsigned MAX_REF_LEN = MaxRefLenDef,
  parameter int unsigned HIST_BINS   = HistBinsDef,
  parameter int unsigned DEPTH_WIDTH = DepthWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic [1:0]            mode_i,
  input  logic [ChromWidth-1:0] chrom_id_i,
  input  logic [LenWidth-1:0]   chrom_length_i,
  input  logic [PosWidth-1:0]   start_pos_i,
  input  logic [PosWidth-1:0]   end_pos_i,
  input  logic                  read_unmapped_i,
  input  logic                  mate_unmapped_i,
  input  logic [BinWidth-1:0]   bin_index_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic                  order_error_o,
  output logic [CountWidth-1:0] bin_count_o
);
  logic f_valid, f_ready, q_valid, q_ready, init_busy, fr_ready;
  cmd_t f_cmd, q_cmd;

  assign ready_o = fr_ready & !init_busy;

  cdh_front #(.MaxRefLen(MAX_REF_LEN)) u_front (
    .clk_i, .rst_ni,
    .valid_i(valid_i & !init_busy), .ready_o(fr_ready),
    .mode_i, .chrom_id_i, .chrom_length_i, .start_pos_i, .end_pos_i,
    .read_unmapped_i, .mate_unmapped_i, .bin_index_i,
    .cmd_valid_o(f_valid), .cmd_ready_i(f_ready), .cmd_o(f_cmd)
  );

  cdh_queue u_queue (
    .clk_i, .rst_ni,
    .in_valid_i(f_valid), .in_ready_o(f_ready), .in_cmd_i(f_cmd),
    .out_valid_o(q_valid), .out_ready_i(q_ready), .out_cmd_o(q_cmd)
  );

  cdh_back #(
    .MaxRefLen(MAX_REF_LEN), .HistBins(HIST_BINS), .DepthWidth(DEPTH_WIDTH)
  ) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(q_valid), .cmd_ready_o(q_ready), .cmd_i(q_cmd),
    .valid_o, .ready_i, .order_error_o, .bin_count_o,
    .init_busy_o(init_busy)
  );

  a_no_accept_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_busy |-> !ready_o) else $error("beat accepted during histogram clear");
  a_err_only_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && order_error_o |-> bin_count_o == '0)
    else $error("order error with nonzero count");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(bin_count_o))
    else $error("result changed while stalled");
endmodule
`default_nettype wire

>>> design/cdh_front.sv
// Front part: checks order and unmapped flags, and classifies each beat.
`default_nettype none
module cdh_front
  import cdh_pkg::*;
#(
  parameter int unsigned MaxRefLen = MaxRefLenDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic [1:0]            mode_i,
  input  logic [ChromWidth-1:0] chrom_id_i,
  input  logic [LenWidth-1:0]   chrom_length_i,
  input  logic [PosWidth-1:0]   start_pos_i,
  input  logic [PosWidth-1:0]   end_pos_i,
  input  logic                  read_unmapped_i,
  input  logic                  mate_unmapped_i,
  input  logic [BinWidth-1:0]   bin_index_i,
  output logic                  cmd_valid_o,
  input  logic                  cmd_ready_i,
  output cmd_t                  cmd_o
);
  logic                  seen_q;
  logic [ChromWidth-1:0] last_chrom_q;
  logic [PosWidth-1:0]   last_start_q;
  cmd_t                  cmd;
  logic                  fire, is_order_err, new_chrom, ok_align;
  logic [LenWidth-1:0]   clip;

  assign ready_o     = cmd_ready_i;
  assign cmd_valid_o = valid_i;
  assign fire        = valid_i & cmd_ready_i;

  assign is_order_err = seen_q && (chrom_id_i < last_chrom_q ||
                        (chrom_id_i == last_chrom_q && start_pos_i < last_start_q));
  assign ok_align  = (mode_i == ModeAlign) && !read_unmapped_i && !mate_unmapped_i
                     && !is_order_err;
  assign new_chrom = !seen_q || chrom_id_i != last_chrom_q;
  // The limit can be wider than the length field; then no clipping is needed.
  assign clip = (32'(chrom_length_i) > MaxRefLen) ? LenWidth'(MaxRefLen) :
                chrom_length_i;

  always_comb begin
    cmd           = '0;
    cmd.start_pos = start_pos_i;
    cmd.end_pos   = end_pos_i;
    cmd.bin_index = bin_index_i;
    cmd.new_len   = clip;
    unique case (mode_i)
      ModeAlign: begin
        cmd.order_err = !read_unmapped_i && !mate_unmapped_i && is_order_err;
        cmd.do_sweep  = ok_align && new_chrom;
        cmd.set_len   = ok_align && new_chrom;
        cmd.do_incr   = ok_align;
      end
      ModeFlush: cmd.do_sweep = seen_q;
      ModeRead:  cmd.do_read  = 1'b1;
      default:   cmd.do_read  = 1'b0;
    endcase
  end
  assign cmd_o = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q       <= 1'b0;
      last_chrom_q <= '0;
      last_start_q <= '0;
    end else if (fire && ok_align) begin
      seen_q       <= 1'b1;
      last_chrom_q <= chrom_id_i;
      last_start_q <= start_pos_i;
    end
  end
endmodule
`default_nettype wire

>>> design/cdh_queue.sv
// Two-entry queue between the front and back parts.
`default_nettype none
module cdh_queue
  import cdh_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  cmd_t in_cmd_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t out_cmd_o
);
  cmd_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o  = cnt_q != 2'd2;
  assign out_valid_o = cnt_q != 2'd0;
  assign out_cmd_o   = mem_q[rd_q];
  assign push = in_valid_i & in_ready_o;
  assign pop  = out_valid_o & out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

>>> design/cdh_back.sv
// Back part: depth store sweeps, range increments and histogram reads.
`default_nettype none
module cdh_back
  import cdh_pkg::*;
#(
  parameter int unsigned MaxRefLen  = MaxRefLenDef,
  parameter int unsigned HistBins   = HistBinsDef,
  parameter int unsigned DepthWidth = DepthWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  output logic                  cmd_ready_o,
  input  cmd_t                  cmd_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic                  order_error_o,
  output logic [CountWidth-1:0] bin_count_o,
  output logic                  init_busy_o
);
  localparam int unsigned AW = $clog2(MaxRefLen);
  localparam int unsigned HW = $clog2(HistBins);
  localparam int unsigned CW = (AW + 1 > PosWidth + 1) ? AW + 1 : PosWidth + 1;
  localparam int unsigned InitLen = (MaxRefLen > HistBins) ? MaxRefLen : HistBins;
  localparam int unsigned IW = $clog2(InitLen) + 1;
  localparam logic [HW-1:0] TopBin = HW'(HistBins - 1);

  localparam logic [3:0] SInit  = 4'd0;
  localparam logic [3:0] SIdle  = 4'd1;
  localparam logic [3:0] SSwRd  = 4'd2;
  localparam logic [3:0] SSwWt  = 4'd3;
  localparam logic [3:0] SSwHr  = 4'd4;
  localparam logic [3:0] SSwHw  = 4'd5;
  localparam logic [3:0] SIncRd = 4'd6;
  localparam logic [3:0] SIncWt = 4'd7;
  localparam logic [3:0] SIncWr = 4'd8;
  localparam logic [3:0] SHRd   = 4'd9;
  localparam logic [3:0] SHWt   = 4'd10;
  localparam logic [3:0] SOut   = 4'd11;

  logic [DepthWidth-1:0] depth_mem [MaxRefLen];
  logic [CountWidth-1:0] hist_mem  [HistBins];

  logic [3:0]            st_q;
  cmd_t                  c_q;
  logic [CW-1:0]         len_q, idx_q, stop_q;
  logic [DepthWidth-1:0] d_rd_q;
  logic [CountWidth-1:0] h_rd_q;
  logic [HW-1:0]         bin_q;
  logic                  res_v_q, res_err_q;
  logic [CountWidth-1:0] res_cnt_q;
  logic [IW-1:0]         init_q;

  logic                  d_we, h_we;
  logic [AW-1:0]         d_wa, d_ra;
  logic [DepthWidth-1:0] d_wd;
  logic [HW-1:0]         h_wa, h_ra;
  logic [CountWidth-1:0] h_wd;
  logic [CW-1:0]         end_lim, inc_stop;
  logic                  inc_go, sweep_last;

  assign cmd_ready_o   = st_q == SIdle && !res_v_q;
  assign valid_o       = res_v_q;
  assign order_error_o = res_err_q;
  assign bin_count_o   = res_cnt_q;
  assign init_busy_o   = st_q == SInit;

  always_ff @(posedge clk_i) begin
    if (d_we) depth_mem[d_wa] <= d_wd;
    d_rd_q <= depth_mem[d_ra];
  end
  always_ff @(posedge clk_i) begin
    if (h_we) hist_mem[h_wa] <= h_wd;
    h_rd_q <= hist_mem[h_ra];
  end

  // Increment range end, exclusive, clipped to the active length.
  always_comb begin
    end_lim = CW'(cmd_i.end_pos) + CW'(1);
    if (end_lim > (cmd_i.set_len ? CW'(cmd_i.new_len) : len_q)) begin
      end_lim = cmd_i.set_len ? CW'(cmd_i.new_len) : len_q;
    end
  end

  // After a sweep on a chromosome change the range is clipped to the new length.
  assign inc_stop   = (CW'(c_q.end_pos) + CW'(1) > CW'(c_q.new_len)) ?
                      CW'(c_q.new_len) : CW'(c_q.end_pos) + CW'(1);
  assign inc_go     = CW'(c_q.start_pos) < inc_stop;
  assign sweep_last = idx_q + CW'(1) >= stop_q;

  always_comb begin
    d_we = 1'b0;
    d_wa = idx_q[AW-1:0];
    d_wd = '0;
    d_ra = idx_q[AW-1:0];
    h_we = 1'b0;
    h_wa = bin_q;
    h_wd = (&h_rd_q) ? h_rd_q : h_rd_q + CountWidth'(1);
    h_ra = bin_q;
    unique case (st_q)
      SInit: begin
        d_we = 32'(init_q) < MaxRefLen;
        d_wa = init_q[AW-1:0];
        h_we = 32'(init_q) < HistBins;
        h_wa = init_q[HW-1:0];
        h_wd = '0;
      end
      SSwHw: begin
        h_we = 1'b1;
        d_we = 1'b1;
      end
      SIncWr: begin
        d_we = 1'b1;
        d_wd = (&d_rd_q) ? d_rd_q : d_rd_q + DepthWidth'(1);
      end
      SHRd: h_ra = HW'(c_q.bin_index);
      default: d_we = 1'b0;
    endcase
  end

  // Both stores are cleared once after reset; after that a depth returns to
  // zero as it is counted, so a sweep leaves the store all zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= SInit;
      len_q     <= '0;
      idx_q     <= '0;
      stop_q    <= '0;
      res_v_q   <= 1'b0;
      res_err_q <= 1'b0;
      res_cnt_q <= '0;
      init_q    <= '0;
      c_q       <= '0;
      bin_q     <= '0;
    end else begin
      if (st_q == SOut) res_v_q <= 1'b1;
      else if (ready_i) res_v_q <= 1'b0;
      unique case (st_q)
        SInit: begin
          init_q <= init_q + IW'(1);
          if (init_q == IW'(InitLen - 1)) st_q <= SIdle;
        end
        SIdle: begin
          if (cmd_valid_i && !res_v_q) begin
            c_q       <= cmd_i;
            res_err_q <= cmd_i.order_err;
            res_cnt_q <= '0;
            if (cmd_i.do_sweep && len_q != '0) begin
              idx_q  <= '0;
              stop_q <= len_q;
              st_q   <= SSwRd;
            end else if (cmd_i.do_incr) begin
              if (cmd_i.set_len) len_q <= CW'(cmd_i.new_len);
              idx_q  <= CW'(cmd_i.start_pos);
              stop_q <= end_lim;
              st_q   <= (CW'(cmd_i.start_pos) < end_lim) ? SIncRd : SOut;
            end else if (cmd_i.do_read) begin
              st_q <= (32'(cmd_i.bin_index) < HistBins) ? SHRd : SOut;
            end else begin
              st_q <= SOut;
            end
          end
        end
        SSwRd: st_q <= SSwWt;
        SSwWt: begin
          if (d_rd_q != '0) begin
            bin_q <= (32'(d_rd_q) >= 32'(HistBins - 1)) ? TopBin : HW'(d_rd_q);
            st_q  <= SSwHr;
          end else if (sweep_last) begin
            if (c_q.set_len) len_q <= CW'(c_q.new_len);
            if (c_q.do_incr) begin
              idx_q  <= CW'(c_q.start_pos);
              stop_q <= inc_stop;
              st_q   <= inc_go ? SIncRd : SOut;
            end else begin
              st_q <= SOut;
            end
          end else begin
            idx_q <= idx_q + CW'(1);
            st_q  <= SSwRd;
          end
        end
        SSwHr: st_q <= SSwHw;
        SSwHw: begin
          if (sweep_last) begin
            if (c_q.set_len) len_q <= CW'(c_q.new_len);
            if (c_q.do_incr) begin
              idx_q  <= CW'(c_q.start_pos);
              stop_q <= inc_stop;
              st_q   <= inc_go ? SIncRd : SOut;
            end else begin
              st_q <= SOut;
            end
          end else begin
            idx_q <= idx_q + CW'(1);
            st_q  <= SSwRd;
          end
        end
        SIncRd: st_q <= SIncWt;
        SIncWt: st_q <= SIncWr;
        SIncWr: begin
          if (idx_q + CW'(1) >= stop_q) begin
            st_q <= SOut;
          end else begin
            idx_q <= idx_q + CW'(1);
            st_q  <= SIncRd;
          end
        end
        SHRd: st_q <= SHWt;
        SHWt: begin
          res_cnt_q <= h_rd_q;
          st_q      <= SOut;
        end
        SOut: st_q <= SIdle;
        default: st_q <= SIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> verif/tb.sv
// Self-checking testbench for the coverage depth histogram block.
`default_nettype none
module tb;
  import cdh_pkg::*;

  typedef struct {
    logic [1:0]            mode;
    logic [ChromWidth-1:0] chrom;
    logic [LenWidth-1:0]   clen;
    logic [PosWidth-1:0]   spos;
    logic [PosWidth-1:0]   epos;
    logic                  runmap;
    logic                  munmap;
    logic [BinWidth-1:0]   bin;
  } beat_t;

  typedef struct {
    logic                  order_err;
    logic [CountWidth-1:0] count;
  } result_t;

  typedef struct {
    beat_t   cmd;
    bit      typed;
    result_t exp_res;
  } row_t;

  localparam logic [1:0] ModeIgnored = 2'd3;
  localparam int unsigned TopBin = HistBinsDef - 1;
  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};
  localparam int unsigned DepthMax = (1 << DepthWidthDef) - 1;
  localparam longint unsigned CycleLimit = 30_000_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic ready_i = 1'b0;
  logic [1:0] mode_i = '0;
  logic [ChromWidth-1:0] chrom_id_i = '0;
  logic [LenWidth-1:0] chrom_length_i = '0;
  logic [PosWidth-1:0] start_pos_i = '0;
  logic [PosWidth-1:0] end_pos_i = '0;
  logic read_unmapped_i = 1'b0;
  logic mate_unmapped_i = 1'b0;
  logic [BinWidth-1:0] bin_index_i = '0;
  logic ready_o, valid_o, order_error_o;
  logic [CountWidth-1:0] bin_count_o;

  coverage_depth_histogram_top DUT (.*);

  always #1 clk_i = ~clk_i;

  // Predictor state; depths are kept sparse since most positions stay zero.
  int unsigned depth_map[int unsigned];
  logic [CountWidth-1:0] hist_model[HistBinsDef];
  bit seen_chrom;
  int unsigned prev_chrom, prev_start, cur_length;

  result_t pending_results[$];
  row_t dir_rows[$];
  int unsigned errors, beats_sent, results_seen, order_errs, reads_done;
  longint unsigned cycles;

  function automatic void sweep_depths();
    int unsigned b;
    foreach (depth_map[p]) begin
      if (depth_map[p] != 0) begin
        b = (depth_map[p] >= TopBin) ? TopBin : depth_map[p];
        if (hist_model[b] != CountMax) hist_model[b]++;
      end
    end
    depth_map.delete();
  endfunction

  function automatic result_t predict_beat(beat_t c);
    result_t r;
    int unsigned lim;
    r.order_err = 1'b0;
    r.count = '0;
    case (c.mode)
      ModeAlign: begin
        if (c.runmap || c.munmap) return r;
        if (seen_chrom && (c.chrom < prev_chrom ||
            (c.chrom == prev_chrom && c.spos < prev_start))) begin
          r.order_err = 1'b1;
          return r;
        end
        if (!seen_chrom || c.chrom != prev_chrom) begin
          sweep_depths();
          cur_length = (c.clen > MaxRefLenDef) ? MaxRefLenDef : c.clen;
        end
        lim = (c.epos + 1 < cur_length) ? c.epos + 1 : cur_length;
        for (int unsigned p = c.spos; p < lim; p++) begin
          if (!depth_map.exists(p)) depth_map[p] = 0;
          if (depth_map[p] < DepthMax) depth_map[p]++;
        end
        seen_chrom = 1'b1;
        prev_chrom = c.chrom;
        prev_start = c.spos;
      end
      ModeFlush: if (seen_chrom) sweep_depths();
      ModeRead: r.count = hist_model[c.bin];
      default: ;
    endcase
    return r;
  endfunction

  // Sends one beat, records its expectation on acceptance, then sometimes idles.
  task automatic send_beat(beat_t c, bit typed, result_t typed_res);
    result_t r;
    int unsigned gap;
    mode_i = c.mode;
    chrom_id_i = c.chrom;
    chrom_length_i = c.clen;
    start_pos_i = c.spos;
    end_pos_i = c.epos;
    read_unmapped_i = c.runmap;
    mate_unmapped_i = c.munmap;
    bin_index_i = c.bin;
    valid_i = 1'b1;
    do @(posedge clk_i); while (!ready_o);
    r = predict_beat(c);
    if (typed) r = typed_res;
    pending_results.insert(pending_results.size(), r);
    beats_sent++;
    @(negedge clk_i);
    gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) :
          ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    if (gap != 0) begin
      valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic send_pred(beat_t c);
    result_t none;
    none.order_err = 1'b0;
    none.count = '0;
    send_beat(c, 1'b0, none);
  endtask

  function automatic beat_t mk(logic [1:0] m, int unsigned ch, int unsigned ln,
                               int unsigned s, int unsigned e, int unsigned ru,
                               int unsigned mu, int unsigned b);
    beat_t c;
    c.mode = m; c.chrom = ChromWidth'(ch); c.clen = LenWidth'(ln);
    c.spos = PosWidth'(s); c.epos = PosWidth'(e);
    c.runmap = ru[0]; c.munmap = mu[0]; c.bin = BinWidth'(b);
    return c;
  endfunction

  function automatic row_t row(beat_t c, int unsigned typed, int unsigned oe,
                               longint unsigned cnt);
    row_t t;
    t.cmd = c;
    t.typed = typed[0];
    t.exp_res.order_err = oe[0];
    t.exp_res.count = CountWidth'(cnt);
    return t;
  endfunction

  function automatic void add_row(row_t t);
    dir_rows.insert(dir_rows.size(), t);
  endfunction

  // Receiver stalls: mostly short, sometimes long, with stretches of none.
  always @(negedge clk_i) begin
    if (!rst_ni) ready_i <= 1'b0;
    else if (ready_i && $urandom_range(0, 3) == 0) ready_i <= 1'b0;
    else if (!ready_i && $urandom_range(0, 9) != 0) ready_i <= 1'b1;
    else if (!ready_i && $urandom_range(0, 30) == 0) ready_i <= 1'b1;
  end

  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && valid_o && ready_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected (order_error %0b count %0d)",
                 $time, order_error_o, bin_count_o);
      end else begin
        e = pending_results.pop_front();
        if (order_error_o !== e.order_err) begin
          errors++;
          $display("%0t: order_error expected %0b actual %0b", $time, e.order_err,
                   order_error_o);
        end
        if (bin_count_o !== e.count) begin
          errors++;
          $display("%0t: bin_count expected %0d actual %0d", $time, e.count,
                   bin_count_o);
        end
        if (e.order_err) order_errs++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int unsigned chrom, clen, pos, n, k;

    foreach (hist_model[i]) hist_model[i] = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    add_row(row(mk(ModeRead, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0));
    add_row(row(mk(ModeFlush, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0));
    add_row(row(mk(ModeIgnored, 16'hffff, 21'h1fffff, 20'hfffff, 20'hfffff,
                   1, 1, 10'h3ff), 1, 0, 0));
    add_row(row(mk(ModeAlign, 5, 10, 2, 6, 0, 0, 0), 0, 0, 0));
    add_row(row(mk(ModeAlign, 5, 10, 4, 20'hfffff, 0, 0, 0), 0, 0, 0));
    add_row(row(mk(ModeAlign, 5, 10, 3, 4, 0, 0, 0), 1, 1, 0));
    add_row(row(mk(ModeAlign, 4, 10, 9, 9, 0, 0, 0), 1, 1, 0));
    add_row(row(mk(ModeAlign, 0, 0, 0, 0, 1, 0, 0), 1, 0, 0));
    add_row(row(mk(ModeAlign, 0, 7, 0, 3, 0, 1, 0), 1, 0, 0));
    add_row(row(mk(ModeAlign, 5, 10, 8, 7, 0, 0, 0), 0, 0, 0));
    add_row(row(mk(ModeAlign, 5, 10, 12, 20, 0, 0, 0), 0, 0, 0));
    add_row(row(mk(ModeFlush, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0));
    add_row(row(mk(ModeRead, 0, 0, 0, 0, 0, 0, 1), 0, 0, 0));
    add_row(row(mk(ModeRead, 0, 0, 0, 0, 0, 0, 2), 0, 0, 0));
    add_row(row(mk(ModeAlign, 5, 10, 12, 13, 0, 0, 0), 0, 0, 0));
    add_row(row(mk(ModeAlign, 5, 10, 13, 14, 0, 0, 0), 0, 0, 0));
    // Length above the maximum is clipped; the last position still counts.
    add_row(row(mk(ModeAlign, 6, 21'h1fffff, 20'hffffe, 20'hfffff, 0, 0, 0),
                0, 0, 0));
    add_row(row(mk(ModeAlign, 6, 0, 20'hfffff, 20'hfffff, 0, 0, 0), 0, 0, 0));
    add_row(row(mk(ModeAlign, 7, 0, 0, 5, 0, 0, 0), 0, 0, 0));
    add_row(row(mk(ModeAlign, 8, 1048576, 0, 0, 0, 0, 0), 0, 0, 0));
    add_row(row(mk(ModeAlign, 9, 4, 0, 3, 0, 0, 0), 0, 0, 0));
    add_row(row(mk(ModeRead, 0, 0, 0, 0, 0, 0, 1), 0, 0, 0));
    add_row(row(mk(ModeRead, 0, 0, 0, 0, 0, 0, 2), 0, 0, 0));
    add_row(row(mk(ModeRead, 0, 0, 0, 0, 0, 0, 10'h3ff), 0, 0, 0));
    foreach (dir_rows[i]) send_beat(dir_rows[i].cmd, dir_rows[i].typed,
                                    dir_rows[i].exp_res);

    // Hold the sender until the block has drained.
    valid_i = 1'b0;
    wait (pending_results.size() == 0);
    @(negedge clk_i);

    // A short chromosome stacked deep enough to reach the top bin.
    for (int i = 0; i < 1040; i++) begin
      if (i % 250 == 249) send_pred(mk(ModeRead, 0, 0, 0, 0, 0, 0, TopBin));
      else send_pred(mk(ModeAlign, 10, 8, 0, $urandom_range(0, 7), 0, 0, 0));
    end
    send_pred(mk(ModeFlush, 0, 0, 0, 0, 0, 0, 0));
    send_pred(mk(ModeRead, 0, 0, 0, 0, 0, 0, TopBin));

    chrom = 10;
    while (beats_sent < 1400 - 9) begin
      chrom = (chrom + $urandom_range(1, 400) > 16'hfffe) ? 16'hffff :
              chrom + $urandom_range(1, 400);
      clen = $urandom_range(1, 2000);
      pos = 0;
      n = $urandom_range(3, 25);
      for (k = 0; k < n; k++) begin
        case ($urandom_range(0, 19))
          0: send_pred(mk(ModeAlign, $urandom, $urandom, $urandom, $urandom,
                          1, $urandom_range(0, 1), $urandom));
          1: send_pred(mk(ModeAlign, $urandom, $urandom, $urandom, $urandom,
                          0, 1, $urandom));
          2: send_pred(mk(ModeAlign, $urandom_range(0, chrom), clen,
                          $urandom_range(0, pos), pos + 5, 0, 0, 0));
          3: send_pred(mk(ModeFlush, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom));
          4, 5: send_pred(mk(ModeRead, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom,
                          $urandom_range(0, 1) ? $urandom_range(0, 30) : $urandom));
          default: begin
            pos = pos + $urandom_range(0, clen / 6);
            if (pos > 20'hfffff) pos = 20'hfffff;
            send_pred(mk(ModeAlign, chrom, clen, pos,
                         ($urandom_range(0, 9) == 0) ? pos - 1 :
                         pos + $urandom_range(0, 150), 0, 0, 0));
          end
        endcase
      end
      if (chrom == 16'hffff) chrom = 10;
    end
    send_pred(mk(ModeFlush, 0, 0, 0, 0, 0, 0, 0));
    for (int b = 0; b < 8; b++) send_pred(mk(ModeRead, 0, 0, 0, 0, 0, 0, b));

    valid_i = 1'b0;
    wait (pending_results.size() == 0);
    repeat (200) @(posedge clk_i);
    $display("Sent %0d beats, checked %0d results, %0d of them order errors.",
             beats_sent, results_seen, order_errs);
    $display("Covered flush, clipping, unmapped drops, mode 3 and the top bin.");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire
